// ===== hdl/gsa_pkg.sv =====
// Shared definitions for the generational slot allocator: stream field widths,
// command and status codes, and the free-stack control bundle.
// No dependencies.
package gsa_pkg;

  // Default sizes of the slot table.
  localparam int SLOT_COUNT_DEF = 64;
  localparam int GEN_BITS_DEF   = 16;
  localparam int OWNER_BITS_DEF = 16;

  // Input stream fields.
  localparam int OWNER_ID_W     = 16;
  localparam int HANDLE_VALID_W = 1;
  localparam int HANDLE_INDEX_W = 6;
  localparam int HANDLE_GEN_W   = 16;

  localparam int OWNER_ID_LSB     = 0;
  localparam int HANDLE_VALID_LSB = OWNER_ID_LSB + OWNER_ID_W;
  localparam int HANDLE_INDEX_LSB = HANDLE_VALID_LSB + HANDLE_VALID_W;
  localparam int HANDLE_GEN_LSB   = HANDLE_INDEX_LSB + HANDLE_INDEX_W;
  localparam int S_TDATA_W        = 40;
  localparam int S_TUSER_W        = 1;

  // Output stream fields.
  localparam int SLOT_INDEX_W   = 6;
  localparam int SLOT_GEN_W     = 16;
  localparam int SLOT_INDEX_LSB = 0;
  localparam int SLOT_GEN_LSB   = SLOT_INDEX_LSB + SLOT_INDEX_W;
  localparam int M_TDATA_W      = 24;
  localparam int M_TUSER_W      = 2;

  // Command codes carried on the input tuser.
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Result status carried on the output tuser.
  typedef enum logic [M_TUSER_W-1:0] {
    ST_ALLOCATED = 2'd0,
    ST_RELEASED  = 2'd1,
    ST_REJECTED  = 2'd2,
    ST_FULL      = 2'd3
  } gsa_status_t;

  // Control of the free stack from the command sequencer.
  typedef struct packed {
    logic rd;    // read the top entry into the output register
    logic pop;   // drop the top entry
    logic push;  // write a new entry on top
  } gsa_stk_ctl_t;

endpackage

// ===== hdl/gsa_slot_ram.sv =====
// Slot table memory of the generational slot allocator: one write port and one
// read port with registered read data. No dependencies.
module gsa_slot_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/gsa_free_stack.sv =====
// LIFO of freed slots for the generational slot allocator. Each entry holds
// an index and the generation it was released with. Depends on gsa_pkg.
module gsa_free_stack #(
  parameter int SLOT_COUNT = 64,
  parameter int ENTRY_W    = 22
) (
  input  logic                              clk,
  input  logic                              rst,
  input  gsa_pkg::gsa_stk_ctl_t             ctl,
  input  logic [ENTRY_W-1:0]                push_data,
  output logic [ENTRY_W-1:0]                top_data,
  output logic [$clog2(SLOT_COUNT+1)-1:0]   depth
);
  import gsa_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  logic [ENTRY_W-1:0] mem [SLOT_COUNT];
  logic [CNT_W-1:0]   depth_m1;
  logic               full;

  assign depth_m1 = depth - CNT_W'(1);
  assign full     = (depth == CNT_W'(SLOT_COUNT));

  always_ff @(posedge clk) begin
    if (ctl.push && !full) begin
      mem[depth[IDX_W-1:0]] <= push_data;
    end
    if (ctl.rd) begin
      top_data <= mem[depth_m1[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (ctl.push && !full) begin
      depth <= depth + CNT_W'(1);
    end else if (ctl.pop && depth != '0) begin
      depth <= depth_m1;
    end
  end

endmodule

// ===== hdl/generational_slot_allocator.sv =====
// Generational slot allocator. Each command arrives as one transfer on the
// slave stream (tuser selects allocate or release) and yields exactly one
// transfer on the master stream with the slot index, its generation and a
// status. Allocation reuses the most recently released slot with its
// generation advanced by one, or else the lowest never-used slot at
// generation zero, and reports the table full when neither exists. A release
// is honored only for a valid handle whose slot has been issued, is alive and
// carries the same generation. The cycle of the input transfer issues the
// single memory read a command needs (top of the free stack for an allocate,
// the slot table entry for a release), and the execute state that follows
// writes both memories back and loads the output register. The block
// takes one command at a time; a new command is taken while the previous
// result still waits in the output register, and the write-back waits only
// while that register stays full. The reset leaves the table empty at once;
// there is no clearing pass, since only issued slots and live stack entries
// are ever read.
module generational_slot_allocator #(
  parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF,
  parameter int GEN_BITS   = gsa_pkg::GEN_BITS_DEF,
  parameter int OWNER_BITS = gsa_pkg::OWNER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Command stream.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // tdata from bit 0: owner_id[15:0], handle_valid[16], handle_index[22:17],
  // handle_generation[38:23], zero [39].
  input  logic [gsa_pkg::S_TDATA_W-1:0] s_tdata,
  // tuser: cmd[0] (0 allocate, 1 release).
  input  logic [gsa_pkg::S_TUSER_W-1:0] s_tuser,
  // Result stream.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // tdata from bit 0: slot_index[5:0], slot_generation[21:6], zero [23:22].
  output logic [gsa_pkg::M_TDATA_W-1:0] m_tdata,
  // tuser: status[1:0] (allocated, released, rejected, full).
  output logic [gsa_pkg::M_TUSER_W-1:0] m_tuser
);
  import gsa_pkg::*;

  localparam int IDX_W   = $clog2(SLOT_COUNT);
  localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
  localparam int CMP_W   = (CNT_W > HANDLE_INDEX_W) ? CNT_W : HANDLE_INDEX_W;
  localparam int WORD_W  = OWNER_BITS + 1 + GEN_BITS;  // {owner, alive, gen}
  localparam int ENTRY_W = GEN_BITS + IDX_W;           // {gen, index}

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                      state;
  logic                        cmd;
  logic [OWNER_BITS-1:0]       owner;
  logic                        hvalid;
  logic [HANDLE_INDEX_W-1:0]   hidx;
  logic [GEN_BITS-1:0]         hgen;
  logic [CNT_W-1:0]            used_count;
  logic [CNT_W-1:0]            used_count_next;

  logic                        accept;
  logic                        commit;
  logic [HANDLE_INDEX_W-1:0]   in_hidx;

  // Slot table port signals.
  logic                        slot_rd_en;
  logic [WORD_W-1:0]           slot_rd_data;
  logic                        slot_we;
  logic [IDX_W-1:0]            slot_wa;
  logic [WORD_W-1:0]           slot_wd;
  logic [GEN_BITS-1:0]         slot_gen;
  logic                        slot_alive;

  // Free stack signals.
  gsa_stk_ctl_t                stk_ctl;
  logic [ENTRY_W-1:0]          stk_top;
  logic [ENTRY_W-1:0]          stk_push_data;
  logic [CNT_W-1:0]            stk_depth;
  logic                        do_push;
  logic                        do_pop;

  // Result of the command being executed.
  logic [IDX_W-1:0]            res_idx;
  logic [GEN_BITS-1:0]         res_gen;
  gsa_status_t                 res_status;
  logic                        rel_ok;
  logic [M_TDATA_W-1:0]        res_tdata;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign commit   = (state == S_EXEC) && (!m_tvalid || m_tready);
  assign in_hidx  = s_tdata[HANDLE_INDEX_LSB +: HANDLE_INDEX_W];

  // Only one memory is read per command, in the cycle of the input transfer.
  assign slot_rd_en = accept && (s_tuser[0] == CMD_RELEASE);
  assign stk_ctl.rd = accept && (s_tuser[0] == CMD_ALLOC) && (stk_depth != '0);
  assign stk_ctl.pop  = commit && do_pop;
  assign stk_ctl.push = commit && do_push;

  assign slot_gen   = slot_rd_data[GEN_BITS-1:0];
  assign slot_alive = slot_rd_data[GEN_BITS];

  // A release needs a valid handle, an issued index, a live slot and a
  // matching generation. The issued check also covers indexes past the table.
  assign rel_ok = hvalid && (CMP_W'(hidx) < CMP_W'(used_count)) &&
                  slot_alive && (slot_gen == hgen);

  always_comb begin
    res_idx         = '0;
    res_gen         = '0;
    res_status      = ST_REJECTED;
    slot_we         = 1'b0;
    slot_wa         = IDX_W'(hidx);
    slot_wd         = '0;
    do_push         = 1'b0;
    do_pop          = 1'b0;
    stk_push_data   = {slot_gen, IDX_W'(hidx)};
    used_count_next = used_count;
    if (cmd == CMD_ALLOC) begin
      if (stk_depth != '0) begin
        // Reuse the latest released slot one generation on.
        res_idx    = stk_top[IDX_W-1:0];
        res_gen    = stk_top[IDX_W +: GEN_BITS] + GEN_BITS'(1);
        res_status = ST_ALLOCATED;
        do_pop     = 1'b1;
        slot_we    = 1'b1;
      end else if (used_count != CNT_W'(SLOT_COUNT)) begin
        res_idx         = used_count[IDX_W-1:0];
        res_status      = ST_ALLOCATED;
        used_count_next = used_count + CNT_W'(1);
        slot_we         = 1'b1;
      end else begin
        res_status = ST_FULL;
      end
      slot_wa = res_idx;
      slot_wd = {owner, 1'b1, res_gen};
    end else if (rel_ok) begin
      // The generation stays in the table and travels with the stack entry.
      res_idx    = IDX_W'(hidx);
      res_status = ST_RELEASED;
      slot_we    = 1'b1;
      slot_wd    = {{OWNER_BITS{1'b0}}, 1'b0, slot_gen};
      do_push    = 1'b1;
    end
  end

  always_comb begin
    res_tdata = '0;
    res_tdata[SLOT_INDEX_LSB +: SLOT_INDEX_W] = SLOT_INDEX_W'(res_idx);
    res_tdata[SLOT_GEN_LSB +: SLOT_GEN_W]     = SLOT_GEN_W'(res_gen);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tready && !commit) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state      <= S_IDLE;
            used_count <= used_count_next;
            m_tvalid   <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Command and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd    <= s_tuser[0];
      owner  <= OWNER_BITS'(s_tdata[OWNER_ID_LSB +: OWNER_ID_W]);
      hvalid <= s_tdata[HANDLE_VALID_LSB];
      hidx   <= in_hidx;
      hgen   <= GEN_BITS'(s_tdata[HANDLE_GEN_LSB +: HANDLE_GEN_W]);
    end
    if (commit) begin
      m_tdata <= res_tdata;
      m_tuser <= res_status;
    end
  end

  gsa_slot_ram #(
    .DEPTH (SLOT_COUNT),
    .WIDTH (WORD_W)
  ) u_slot_ram (
    .clk     (clk),
    .rd_en   (slot_rd_en),
    .rd_addr (IDX_W'(in_hidx)),
    .rd_data (slot_rd_data),
    .wr_en   (commit && slot_we),
    .wr_addr (slot_wa),
    .wr_data (slot_wd)
  );

  gsa_free_stack #(
    .SLOT_COUNT (SLOT_COUNT),
    .ENTRY_W    (ENTRY_W)
  ) u_free_stack (
    .clk       (clk),
    .rst       (rst),
    .ctl       (stk_ctl),
    .push_data (stk_push_data),
    .top_data  (stk_top),
    .depth     (stk_depth)
  );

  // The number of issued slots never passes the table size.
  assert property (@(posedge clk) disable iff (rst)
    used_count <= CNT_W'(SLOT_COUNT))
    else $error("issued slot count exceeds the table");

  // Every stacked index was issued before, so the stack is never deeper.
  assert property (@(posedge clk) disable iff (rst)
    stk_depth <= used_count)
    else $error("free stack deeper than the issued slot count");

  // A new result only appears after a command has executed.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_EXEC))
    else $error("result presented without an executed command");

  // An allocated index always lies below the issued slot count.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_ALLOCATED) |->
      CMP_W'(m_tdata[SLOT_INDEX_LSB +: SLOT_INDEX_W]) < CMP_W'(used_count))
    else $error("allocated index beyond the issued slots");

  // An honored release deepens the free stack by one.
  assert property (@(posedge clk) disable iff (rst)
    commit && (cmd == CMD_RELEASE) && rel_ok |=>
      stk_depth == $past(stk_depth) + CNT_W'(1))
    else $error("released slot not pushed on the free stack");

endmodule
